@@ sv/blid_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blid_pkg: shared types for the bounded list core
// Item and result payloads, mode and status codes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package blid_pkg;

  // Default list depth
  localparam int LIST_DEPTH_DEF = 16;

  // Request modes
  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_DELETE   = 2'd1,
    MODE_DUMP_OLD = 2'd2,
    MODE_DUMP_NEW = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Result value source
  typedef enum logic [1:0] {
    OSEL_ITEM  = 2'd0,
    OSEL_ZERO  = 2'd1,
    OSEL_RDATA = 2'd2
  } out_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_RESP,
    S_DEL_RD,
    S_DEL_CMP,
    S_SH_RD,
    S_SH_WR,
    S_DMP_RD,
    S_DMP_OUT
  } state_t;

  // Input request payload
  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] item_value;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic signed [31:0] out_value;
    status_t            status;
    logic               last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     item_ld;
    logic     mem_we;
    logic     mem_re;
    logic     wr_shift;
    logic     out_ld;
    out_sel_t out_sel;
    status_t  out_status;
    logic     out_last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic match;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/blid_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blid_dpath: list datapath
// Entry memory with registered read, request register, match compare and
// the result register that faces the output channel.
// ----------------------------------------------------------------------------
module blid_dpath
  import blid_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  in_item_t            in_data,
  input  dp_cmd_t             cmd,
  input  wire  [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] mem_addr,
  output dp_sts_t             sts,
  output logic                out_valid,
  input  wire                 out_ready,
  output out_item_t           out_data
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic signed [31:0] mem [LIST_DEPTH];
  logic signed [31:0] rdata_r;
  logic signed [31:0] item_value_r;
  logic signed [31:0] wdata;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_item_t          out_data_r;
  out_item_t          out_data_nxt;

  // Hold the accepted request value
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      item_value_r <= in_data.item_value;
    end
  end

  // Entry memory: one address, write or registered read
  assign wdata = cmd.wr_shift ? rdata_r : item_value_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[mem_addr[AW-1:0]] <= wdata;
    end
    if (cmd.mem_re) begin
      rdata_r <= mem[mem_addr[AW-1:0]];
    end
  end

  // Build the next result
  always_comb begin
    out_data_nxt.status = cmd.out_status;
    out_data_nxt.last   = cmd.out_last;
    unique case (cmd.out_sel)
      OSEL_ITEM:  out_data_nxt.out_value = item_value_r;
      OSEL_ZERO:  out_data_nxt.out_value = '0;
      OSEL_RDATA: out_data_nxt.out_value = rdata_r;
      default:    out_data_nxt.out_value = item_value_r;
    endcase
  end

  // Result register: load on command, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.match    = (rdata_r == item_value_r);
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

`default_nettype wire

@@ sv/blid_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blid_ctrl: list controller
// Sequences insert, search and shift for delete, and dumps; owns the entry
// count and the memory pointer.
// ----------------------------------------------------------------------------
module blid_ctrl
  import blid_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  input  mode_t    in_mode,
  input  dp_sts_t  sts,
  output dp_cmd_t  cmd,
  output logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] mem_addr
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r,   ptr_nxt;
  logic [CW-1:0] dcnt_r,  dcnt_nxt;
  mode_t         mode_r,  mode_nxt;
  status_t       resp_st_r, resp_st_nxt;
  logic          resp_zero_r, resp_zero_nxt;
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] ptr_dec;
  logic          dump_last;

  assign ptr_inc   = ptr_r + ONE;
  assign ptr_dec   = ptr_r - ONE;
  assign dump_last = ((dcnt_r + ONE) == count_r);

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      dcnt_r      <= '0;
      mode_r      <= MODE_INSERT;
      resp_st_r   <= ST_OK;
      resp_zero_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      dcnt_r      <= dcnt_nxt;
      mode_r      <= mode_nxt;
      resp_st_r   <= resp_st_nxt;
      resp_zero_r <= resp_zero_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    dcnt_nxt      = dcnt_r;
    mode_nxt      = mode_r;
    resp_st_nxt   = resp_st_r;
    resp_zero_nxt = resp_zero_r;
    in_ready      = 1'b0;
    mem_addr      = ptr_r[AW-1:0];
    cmd           = '0;
    cmd.out_sel   = OSEL_ITEM;
    cmd.out_status = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_ld   = 1'b1;
          mode_nxt      = in_mode;
          resp_zero_nxt = 1'b0;
          dcnt_nxt      = '0;
          unique case (in_mode)
            MODE_INSERT: begin
              state_nxt = S_INS;
            end
            MODE_DELETE: begin
              if (count_r == '0) begin
                resp_st_nxt = ST_EMPTY;
                state_nxt   = S_RESP;
              end else begin
                ptr_nxt   = count_r - ONE;
                state_nxt = S_DEL_RD;
              end
            end
            MODE_DUMP_OLD, MODE_DUMP_NEW: begin
              if (count_r == '0) begin
                resp_st_nxt   = ST_EMPTY;
                resp_zero_nxt = 1'b1;
                state_nxt     = S_RESP;
              end else begin
                ptr_nxt   = (in_mode == MODE_DUMP_OLD) ? '0 : (count_r - ONE);
                state_nxt = S_DMP_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // Append at the newest end unless full
      S_INS: begin
        if (count_r == FULL_CNT) begin
          resp_st_nxt = ST_FULL;
        end else begin
          mem_addr    = count_r[AW-1:0];
          cmd.mem_we  = 1'b1;
          count_nxt   = count_r + ONE;
          resp_st_nxt = ST_OK;
        end
        state_nxt = S_RESP;
      end

      // Emit the single result of insert, delete or an empty dump
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_sel    = resp_zero_r ? OSEL_ZERO : OSEL_ITEM;
          cmd.out_status = resp_st_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      // Search newest to oldest
      S_DEL_RD: begin
        cmd.mem_re = 1'b1;
        state_nxt  = S_DEL_CMP;
      end

      S_DEL_CMP: begin
        priority if (sts.match) begin
          state_nxt = S_SH_RD;
        end else if (ptr_r == '0) begin
          resp_st_nxt = ST_NOTFOUND;
          state_nxt   = S_RESP;
        end else begin
          ptr_nxt   = ptr_dec;
          state_nxt = S_DEL_RD;
        end
      end

      // Close the gap: move entry ptr+1 down to ptr
      S_SH_RD: begin
        if (ptr_inc < count_r) begin
          mem_addr   = ptr_inc[AW-1:0];
          cmd.mem_re = 1'b1;
          state_nxt  = S_SH_WR;
        end else begin
          count_nxt   = count_r - ONE;
          resp_st_nxt = ST_OK;
          state_nxt   = S_RESP;
        end
      end

      S_SH_WR: begin
        cmd.mem_we   = 1'b1;
        cmd.wr_shift = 1'b1;
        ptr_nxt      = ptr_inc;
        state_nxt    = S_SH_RD;
      end

      // Dump one entry per read
      S_DMP_RD: begin
        cmd.mem_re = 1'b1;
        state_nxt  = S_DMP_OUT;
      end

      S_DMP_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_sel    = OSEL_RDATA;
          cmd.out_status = ST_OK;
          cmd.out_last   = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            dcnt_nxt  = dcnt_r + ONE;
            ptr_nxt   = (mode_r == MODE_DUMP_OLD) ? ptr_inc : ptr_dec;
            state_nxt = S_DMP_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/bounded_list_insert_delete_dump_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_dump_core: bounded ordered list of signed words
// Requests arrive on in_valid/in_ready with in_data (mode, item_value).
// Results leave on out_valid/out_ready with out_data (out_value, status,
// last). One request is processed at a time; in_ready is high only while
// the controller is idle.
// Insert: one result.
// Delete: one result; the search reads one entry at a time from the
// newest end, then the shift moves one entry down at a time. Dump: one
// result per entry, one entry at a time, as set by the single read port
// of the entry memory and its registered read.
// A full list refuses an insert with status full; an empty list answers a
// delete or a dump with one result of status empty.
// Reset clears the entry count and the result valid flag; entry contents are
// not cleared and need no pass. A stalled receiver holds the result
// register and the controller waits before loading the next result.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_dump_core
  import blid_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output out_item_t out_data
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] mem_addr;

  // Controller
  blid_ctrl #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_data.mode),
    .sts      (sts),
    .cmd      (cmd),
    .mem_addr (mem_addr)
  );

  // Datapath
  blid_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .mem_addr  (mem_addr),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Busy after an accepted request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in work");

  // Never overwrite a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("result loaded while previous result not taken");

  // Error results always end their request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> out_data.last)
    else $error("non-ok result without last mark");

  // No memory write and read in the same cycle
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_we && cmd.mem_re))
    else $error("memory written and read in one cycle");

endmodule

`default_nettype wire

@@ tb/bounded_list_insert_delete_dump_core_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_dump_core_tb: self-checking bench for the list core
// Sends insert, delete and dump requests and mirrors them in a queue-based
// shadow list that predicts every reply. Each reply is compared field by field
// with the oldest prediction. Directed requests cover the empty list, the full
// list, duplicate values and the field extremes. Random phases first grow and
// then shrink the list. Both sides idle at random, except for one phase with
// no idling at all.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_dump_core_tb;
  import blid_pkg::*;

  localparam int DEPTH         = LIST_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4 * DEPTH + 16;
  localparam int IDLE_PCT      = 11;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Shadow of the list contents, index 0 oldest
  logic signed [31:0] list_shadow[$];
  // Replies the list owes, oldest first
  out_item_t          reply_queue[$];
  int                 fail_count  = 0;
  int unsigned        cycle_count = 0;
  bit                 calm        = 1'b0;

  bounded_list_insert_delete_dump_core #(
    .LIST_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Free-running clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Apply one accepted request to the shadow list and queue its replies
  function automatic void list_apply(input in_item_t req);
    out_item_t rep;
    int        hit;
    int        n;
    rep.out_value = req.item_value;
    rep.status    = ST_OK;
    rep.last      = 1'b1;
    hit           = -1;
    n             = list_shadow.size();
    case (req.mode)
      MODE_INSERT: begin
        if (n >= DEPTH) rep.status = ST_FULL;
        else list_shadow.push_back(req.item_value);
        reply_queue.push_back(rep);
      end
      MODE_DELETE: begin
        // Search from the newest end, drop the first match
        if (n == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          for (int i = n - 1; i >= 0; i--)
            if (hit < 0 && list_shadow[i] == req.item_value) hit = i;
          if (hit < 0) rep.status = ST_NOTFOUND;
          else list_shadow.delete(hit);
        end
        reply_queue.push_back(rep);
      end
      default: begin
        if (n == 0) begin
          rep.out_value = '0;
          rep.status    = ST_EMPTY;
          reply_queue.push_back(rep);
        end else begin
          for (int i = 0; i < n; i++) begin
            rep.out_value = (req.mode == MODE_DUMP_OLD) ? list_shadow[i]
                                                        : list_shadow[n - 1 - i];
            rep.last      = (i == n - 1);
            reply_queue.push_back(rep);
          end
        end
      end
    endcase
  endfunction

  // Offer one request, hold it until accepted, then predict its replies
  task automatic send_request(input mode_t m, input logic signed [31:0] v);
    in_item_t req;
    req.mode       = m;
    req.item_value = v;
    @(posedge clk);
    if (!calm)
      while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    list_apply(req);
    in_valid <= 1'b0;
  endtask

  // Drive the result side and check every reply against the shadow list
  always @(posedge clk) begin : check_replies
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (reply_queue.size() == 0) begin
          fail_count++;
          $display("%0t unexpected reply: expected none, got value %0d status %0d last %0d",
                   $time, out_data.out_value, out_data.status, out_data.last);
        end else begin
          want = reply_queue.pop_front();
          if (out_data.out_value !== want.out_value) begin
            fail_count++;
            $display("%0t out_value mismatch: expected %0d, got %0d",
                     $time, want.out_value, out_data.out_value);
          end
          if (out_data.status !== want.status) begin
            fail_count++;
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, want.status, out_data.status);
          end
          if (out_data.last !== want.last) begin
            fail_count++;
            $display("%0t last mismatch: expected %0d, got %0d",
                     $time, want.last, out_data.last);
          end
        end
      end
    end
  end

  // Dumps and deletes on a list that has never held anything
  task automatic test_empty_list();
    send_request(MODE_DUMP_OLD, 32'sd0);
    send_request(MODE_DUMP_NEW, -32'sd1);
    send_request(MODE_DELETE, 32'sh8000_0000);
  endtask

  // Fill to the bound with extremes and a duplicate, then overflow once
  task automatic test_fill_to_full();
    logic signed [31:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7fff_ffff;
        2:       v = 32'sd0;
        3:       v = -32'sd1;
        7, 12:   v = 32'sd7;
        default: v = i * 1000 - 5000;
      endcase
      send_request(MODE_INSERT, v);
    end
    send_request(MODE_INSERT, 32'sd99);
    send_request(MODE_DUMP_OLD, 32'sd0);
  endtask

  // Remove the newer duplicate, miss once, remove the oldest entry
  task automatic test_delete_cases();
    send_request(MODE_DELETE, 32'sd7);
    send_request(MODE_DELETE, 32'sd424242);
    send_request(MODE_DELETE, 32'sh8000_0000);
    send_request(MODE_DUMP_NEW, 32'sd5);
  endtask

  // Random requests; insert_pct steers the list toward full or empty
  task automatic test_random_mix(input int count, input int insert_pct);
    int                 roll;
    mode_t              m;
    logic signed [31:0] v;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) m = MODE_INSERT;
      else if (roll < insert_pct + (100 - insert_pct) * 3 / 4) m = MODE_DELETE;
      else m = $urandom_range(0, 1) ? MODE_DUMP_OLD : MODE_DUMP_NEW;
      // Mostly hit stored values and a narrow range so duplicates and matches occur
      roll = $urandom_range(0, 99);
      if (m == MODE_DELETE && list_shadow.size() != 0 && roll < 60)
        v = list_shadow[$urandom_range(0, list_shadow.size() - 1)];
      else if (roll < 80)
        v = int'($urandom_range(0, 6)) - 3;
      else
        v = $urandom;
      send_request(m, v);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_to_full();
    test_delete_cases();
    test_random_mix(80, 70);
    calm = 1'b1;
    test_random_mix(50, 45);
    calm = 1'b0;
    test_random_mix(70, 25);

    // Drain outstanding replies, then watch for strays
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
